// ===== src/rsmts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsmts_pkg
// Shared types and constants for the strength index / moving average signal unit.
// ----------------------------------------------------------------------------
package rsmts_pkg;

  localparam int unsigned CFG_ADDR_BITS = 3;
  localparam int unsigned CFG_DATA_BITS = 7;
  localparam int unsigned COUNT_BITS    = 7;
  localparam int unsigned OUT_BITS      = 8;

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    REG_RSI_PERIOD        = 3'd0,
    REG_MA_PERIOD         = 3'd1,
    REG_MIN_HISTORY       = 3'd2,
    REG_STRONG_BUY_LEVEL  = 3'd3,
    REG_BUY_LEVEL         = 3'd4,
    REG_STRONG_SELL_LEVEL = 3'd5,
    REG_SELL_LEVEL        = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [5:0] rsi_period;
    logic [5:0] ma_period;
    logic [5:0] min_history;
    logic [6:0] strong_buy_level;
    logic [6:0] buy_level;
    logic [6:0] strong_sell_level;
    logic [6:0] sell_level;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    rsi_period:        6'd14,
    ma_period:         6'd20,
    min_history:       6'd14,
    strong_buy_level:  7'd30,
    buy_level:         7'd40,
    strong_sell_level: 7'd70,
    sell_level:        7'd60
  };

  typedef enum logic [1:0] {
    KIND_NEUTRAL = 2'd0,
    KIND_FULL    = 2'd1,
    KIND_RATIO   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    SIG_HOLD        = 3'd0,
    SIG_STRONG_BUY  = 3'd1,
    SIG_BUY         = 3'd2,
    SIG_SELL        = 3'd3,
    SIG_STRONG_SELL = 3'd4
  } sig_t;

  localparam logic [6:0] IDX_NEUTRAL_VAL = 7'd50;
  localparam logic [6:0] IDX_FULL_VAL    = 7'd100;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = 7'd127;

endpackage

// ===== src/rsmts_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsmts_front
// Takes closes one per cycle while the queue is not full, keeps the running sums
// and pushes a series summary into the queue on the last close.
// ----------------------------------------------------------------------------
module rsmts_front import rsmts_pkg::*; #(
  parameter int unsigned PRICE_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [PRICE_BITS-1:0]   close_price,
  input  logic [PRICE_BITS-1:0]   current_price,
  input  logic                    last_close,
  input  cfg_t                    cfg,
  input  logic                    q_full,
  output logic                    push,
  output logic [PRICE_BITS+5:0]   push_gain,
  output logic [PRICE_BITS+5:0]   push_loss,
  output logic [PRICE_BITS+5:0]   push_close_total,
  output logic [PRICE_BITS-1:0]   push_price,
  output logic [COUNT_BITS-1:0]   push_count
);

  localparam int unsigned TOT_BITS = PRICE_BITS + 6;

  logic [PRICE_BITS-1:0] previous_close;
  logic [COUNT_BITS-1:0] close_count;
  logic [TOT_BITS-1:0]   gain_total;
  logic [TOT_BITS-1:0]   loss_total;
  logic [TOT_BITS-1:0]   close_total;

  logic [TOT_BITS-1:0]   gain_total_next;
  logic [TOT_BITS-1:0]   loss_total_next;
  logic [TOT_BITS-1:0]   close_total_next;
  logic [COUNT_BITS-1:0] close_count_next;
  logic [PRICE_BITS-1:0] change;
  logic                  falling;
  logic                  in_rsi;
  logic                  in_ma;
  logic                  accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // newer close minus older close: older close here is the incoming one
  assign falling  = previous_close > close_price;
  assign change   = falling ? (previous_close - close_price) : (close_price - previous_close);
  assign in_rsi   = (close_count != '0) && (close_count <= {1'b0, cfg.rsi_period});
  assign in_ma    = close_count < {1'b0, cfg.ma_period};

  always_comb begin
    gain_total_next  = gain_total;
    loss_total_next  = loss_total;
    close_total_next = close_total;
    if (in_rsi && falling) begin
      gain_total_next = gain_total + TOT_BITS'(change);
    end
    if (in_rsi && !falling) begin
      loss_total_next = loss_total + TOT_BITS'(change);
    end
    if (in_ma) begin
      close_total_next = close_total + TOT_BITS'(close_price);
    end
    close_count_next = (close_count == COUNT_MAX) ? close_count : close_count + 7'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_close <= '0;
      close_count    <= '0;
      gain_total     <= '0;
      loss_total     <= '0;
      close_total    <= '0;
    end else if (accept) begin
      if (last_close) begin
        previous_close <= '0;
        close_count    <= '0;
        gain_total     <= '0;
        loss_total     <= '0;
        close_total    <= '0;
      end else begin
        previous_close <= close_price;
        close_count    <= close_count_next;
        gain_total     <= gain_total_next;
        loss_total     <= loss_total_next;
        close_total    <= close_total_next;
      end
    end
  end

  assign push             = accept && last_close;
  assign push_gain        = gain_total_next;
  assign push_loss        = loss_total_next;
  assign push_close_total = close_total_next;
  assign push_price       = current_price;
  assign push_count       = close_count_next;

endmodule

// ===== src/rsmts_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsmts_queue
// Two-entry queue of series summaries between front and back.
// ----------------------------------------------------------------------------
module rsmts_queue import rsmts_pkg::*; #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full    = count == 2'd2;
  assign empty   = count == 2'd0;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ===== src/rsmts_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsmts_back
// Three-stage decision pipeline: classify, cross-multiply, compare and select.
// ----------------------------------------------------------------------------
module rsmts_back import rsmts_pkg::*; #(
  parameter int unsigned PRICE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cfg_t                  cfg,
  input  logic                  q_empty,
  input  logic [PRICE_BITS+5:0] q_gain,
  input  logic [PRICE_BITS+5:0] q_loss,
  input  logic [PRICE_BITS+5:0] q_close_total,
  input  logic [PRICE_BITS-1:0] q_price,
  input  logic [COUNT_BITS-1:0] q_count,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output sig_t                  out_signal
);

  localparam int unsigned TOT_BITS  = PRICE_BITS + 6;
  localparam int unsigned SUM_BITS  = PRICE_BITS + 7;
  localparam int unsigned G100_BITS = PRICE_BITS + 13;
  localparam int unsigned PROD_BITS = PRICE_BITS + 14;

  logic advance;

  // stage 1
  logic                  v1;
  logic                  hist_ok1;
  kind_t                 kind1;
  logic [5:0]            m1;
  logic [PRICE_BITS-1:0] price1;
  logic [TOT_BITS-1:0]   ct1;
  logic [SUM_BITS-1:0]   gl1;
  logic [G100_BITS-1:0]  g100_1;

  // stage 2
  logic                  v2;
  logic                  hist_ok2;
  logic [TOT_BITS-1:0]   ma_lhs2;
  logic [TOT_BITS-1:0]   ma_rhs2;
  logic [G100_BITS-1:0]  idx_lhs2;
  logic [PROD_BITS-1:0]  sb_rhs2;
  logic [PROD_BITS-1:0]  b_rhs2;
  logic [PROD_BITS-1:0]  ss_rhs2;
  logic [PROD_BITS-1:0]  s_rhs2;

  kind_t                 kind_c;
  logic [5:0]            m_c;
  sig_t                  sig_c;
  logic                  under;
  logic                  over;

  assign advance = !out_valid || out_ready;
  assign pop     = advance && !q_empty;

  always_comb begin
    if (q_count <= {1'b0, cfg.rsi_period}) begin
      kind_c = KIND_NEUTRAL;
    end else if (q_loss == '0) begin
      kind_c = KIND_FULL;
    end else begin
      kind_c = KIND_RATIO;
    end
    m_c = ({1'b0, cfg.ma_period} < q_count) ? cfg.ma_period : q_count[5:0];
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      hist_ok1 <= q_count >= {1'b0, cfg.min_history};
      kind1    <= kind_c;
      m1       <= m_c;
      price1   <= q_price;
      ct1      <= q_close_total;
      gl1      <= SUM_BITS'(q_gain) + SUM_BITS'(q_loss);
      g100_1   <= G100_BITS'(q_gain) * G100_BITS'(IDX_FULL_VAL);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      hist_ok2 <= hist_ok1;
      if (m1 == '0) begin
        ma_lhs2 <= TOT_BITS'(price1);
        ma_rhs2 <= '0;
      end else begin
        ma_lhs2 <= TOT_BITS'(price1) * TOT_BITS'(m1);
        ma_rhs2 <= ct1;
      end
      case (kind1)
        KIND_NEUTRAL: idx_lhs2 <= G100_BITS'(IDX_NEUTRAL_VAL);
        KIND_FULL:    idx_lhs2 <= G100_BITS'(IDX_FULL_VAL);
        default:      idx_lhs2 <= g100_1;
      endcase
      if (kind1 == KIND_RATIO) begin
        sb_rhs2 <= PROD_BITS'(gl1) * PROD_BITS'(cfg.strong_buy_level);
        b_rhs2  <= PROD_BITS'(gl1) * PROD_BITS'(cfg.buy_level);
        ss_rhs2 <= PROD_BITS'(gl1) * PROD_BITS'(cfg.strong_sell_level);
        s_rhs2  <= PROD_BITS'(gl1) * PROD_BITS'(cfg.sell_level);
      end else begin
        sb_rhs2 <= PROD_BITS'(cfg.strong_buy_level);
        b_rhs2  <= PROD_BITS'(cfg.buy_level);
        ss_rhs2 <= PROD_BITS'(cfg.strong_sell_level);
        s_rhs2  <= PROD_BITS'(cfg.sell_level);
      end
    end
  end

  always_comb begin
    under = ma_lhs2 < ma_rhs2;
    over  = ma_lhs2 > ma_rhs2;
    sig_c = SIG_HOLD;
    if (hist_ok2) begin
      if (under && (PROD_BITS'(idx_lhs2) < sb_rhs2)) begin
        sig_c = SIG_STRONG_BUY;
      end else if (under && (PROD_BITS'(idx_lhs2) < b_rhs2)) begin
        sig_c = SIG_BUY;
      end else if (over && (PROD_BITS'(idx_lhs2) > ss_rhs2)) begin
        sig_c = SIG_STRONG_SELL;
      end else if (over && (PROD_BITS'(idx_lhs2) > s_rhs2)) begin
        sig_c = SIG_SELL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_signal <= sig_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      v1        <= !q_empty;
      v2        <= v1;
      out_valid <= v2;
    end
  end

endmodule

// ===== src/rsi_ma_trade_signal_unit.sv =====
`timescale 1ns / 1ps
// Throughput: one close per cycle, stalled only while the summary queue is full.
// Path: the summary of the last close is written into the queue, read into the classify
// stage, then the cross-multiply stage, then compared into the output register.
// The accumulate loop is one subtract and add per close in the front part.
// Reset (rst, synchronous): clears the series sums, queue and pipeline valids,
// and loads the register defaults.
// ----------------------------------------------------------------------------
// rsi_ma_trade_signal_unit
// Strength index and moving average trade signal over one close series.
// ----------------------------------------------------------------------------
module rsi_ma_trade_signal_unit import rsmts_pkg::*; #(
  parameter int unsigned PRICE_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // close_price, current_price
  input  logic [((2*PRICE_BITS+7)/8)*8-1:0]    s_axis_tdata,
  input  logic                                 s_axis_tlast,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // signal
  output logic [OUT_BITS-1:0]                  m_axis_tdata,
  input  logic                                 cfg_we,
  input  logic [CFG_ADDR_BITS-1:0]             cfg_addr,
  input  logic [CFG_DATA_BITS-1:0]             cfg_data
);

  localparam int unsigned TOT_BITS = PRICE_BITS + 6;
  localparam int unsigned Q_WIDTH  = 3 * TOT_BITS + PRICE_BITS + COUNT_BITS;

  cfg_t                  cfg;
  logic                  q_full;
  logic                  q_empty;
  logic                  push;
  logic                  pop;
  logic [TOT_BITS-1:0]   push_gain;
  logic [TOT_BITS-1:0]   push_loss;
  logic [TOT_BITS-1:0]   push_close_total;
  logic [PRICE_BITS-1:0] push_price;
  logic [COUNT_BITS-1:0] push_count;
  logic [Q_WIDTH-1:0]    q_wr_data;
  logic [Q_WIDTH-1:0]    q_rd_data;
  sig_t                  out_signal;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_RSI_PERIOD:        cfg.rsi_period        <= cfg_data[5:0];
        REG_MA_PERIOD:         cfg.ma_period         <= cfg_data[5:0];
        REG_MIN_HISTORY:       cfg.min_history       <= cfg_data[5:0];
        REG_STRONG_BUY_LEVEL:  cfg.strong_buy_level  <= cfg_data;
        REG_BUY_LEVEL:         cfg.buy_level         <= cfg_data;
        REG_STRONG_SELL_LEVEL: cfg.strong_sell_level <= cfg_data;
        REG_SELL_LEVEL:        cfg.sell_level        <= cfg_data;
        default: ;
      endcase
    end
  end

  rsmts_front #(.PRICE_BITS(PRICE_BITS)) u_front (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (s_axis_tvalid),
    .in_ready         (s_axis_tready),
    .close_price      (s_axis_tdata[PRICE_BITS-1:0]),
    .current_price    (s_axis_tdata[2*PRICE_BITS-1:PRICE_BITS]),
    .last_close       (s_axis_tlast),
    .cfg              (cfg),
    .q_full           (q_full),
    .push             (push),
    .push_gain        (push_gain),
    .push_loss        (push_loss),
    .push_close_total (push_close_total),
    .push_price       (push_price),
    .push_count       (push_count)
  );

  assign q_wr_data = {push_count, push_price, push_close_total, push_loss, push_gain};

  rsmts_queue #(.WIDTH(Q_WIDTH)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (q_wr_data),
    .pop     (pop),
    .rd_data (q_rd_data),
    .full    (q_full),
    .empty   (q_empty)
  );

  rsmts_back #(.PRICE_BITS(PRICE_BITS)) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_empty       (q_empty),
    .q_gain        (q_rd_data[TOT_BITS-1:0]),
    .q_loss        (q_rd_data[2*TOT_BITS-1:TOT_BITS]),
    .q_close_total (q_rd_data[3*TOT_BITS-1:2*TOT_BITS]),
    .q_price       (q_rd_data[3*TOT_BITS+PRICE_BITS-1:3*TOT_BITS]),
    .q_count       (q_rd_data[Q_WIDTH-1:3*TOT_BITS+PRICE_BITS]),
    .pop           (pop),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .out_signal    (out_signal)
  );

  assign m_axis_tdata = {{(OUT_BITS-3){1'b0}}, out_signal};

endmodule

// ===== src/rsmts_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsmts_checker
// Port-level checks on the signal unit, bound to the top level.
// ----------------------------------------------------------------------------
module rsmts_checker import rsmts_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                s_axis_tlast,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OUT_BITS-1:0] m_axis_tdata
);

  // series ended at the input but not yet delivered
  logic [3:0] pending;
  logic       in_end;
  logic       out_xfer;

  assign in_end   = s_axis_tvalid && s_axis_tready && s_axis_tlast;
  assign out_xfer = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (in_end && !out_xfer) begin
      pending <= pending + 4'd1;
    end else if (out_xfer && !in_end) begin
      pending <= pending - 4'd1;
    end
  end

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output changed");

  a_signal_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[OUT_BITS-1:3] == '0) && (m_axis_tdata[2:0] <= 3'd4))
    else $error("signal code out of range");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> pending != 4'd0)
    else $error("signal without a finished series");

endmodule

bind rsi_ma_trade_signal_unit rsmts_checker u_rsmts_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
